@@ rtl/core/lfc_pkg.sv @@
// Shared types and constants for the link failover controller.
// Used by lfc_cfg_regs, lfc_core and link_failover_controller; depends on nothing.

package lfc_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned S_TDATA_W  = 40;
	localparam int unsigned M_TDATA_W  = 48;

	localparam logic [CFG_ADDR_W-1:0] REG_ETH_LINK_TO   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ETH_CLOUD_TO  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CELL_LINK_TO  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_CELL_CLOUD_TO = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_ETH_RETRY     = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_ETH_KEEPALIVE = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_CELL_KEEPALIVE = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_BACKUP_COLOR  = 3'd7;

	localparam logic [31:0] RST_ETH_LINK_TO    = 32'd30000;
	localparam logic [31:0] RST_ETH_CLOUD_TO   = 32'd60000;
	localparam logic [31:0] RST_CELL_LINK_TO   = 32'd600000;
	localparam logic [31:0] RST_CELL_CLOUD_TO  = 32'd300000;
	localparam logic [31:0] RST_ETH_RETRY      = 32'd300000;
	localparam logic [31:0] RST_ETH_KEEPALIVE  = 32'd25000;
	localparam logic [31:0] RST_CELL_KEEPALIVE = 32'd1380000;
	localparam logic [23:0] RST_BACKUP_COLOR   = 24'hFFFF00;

	// backup color that selects the default theme instead of a custom one
	localparam logic [23:0] DEFAULT_THEME_COLOR = 24'h00FFFF;

	localparam logic [1:0] LINK_NONE = 2'd0;
	localparam logic [1:0] LINK_ETH  = 2'd1;
	localparam logic [1:0] LINK_CELL = 2'd2;

	localparam logic [1:0] LED_KEEP    = 2'd0;
	localparam logic [1:0] LED_DEFAULT = 2'd1;
	localparam logic [1:0] LED_BACKUP  = 2'd2;

	typedef struct packed {
		logic [31:0] eth_link_timeout_ms;
		logic [31:0] eth_cloud_timeout_ms;
		logic [31:0] cell_link_timeout_ms;
		logic [31:0] cell_cloud_timeout_ms;
		logic [31:0] eth_retry_period_ms;
		logic [31:0] eth_keepalive_ms;
		logic [31:0] cell_keepalive_ms;
		logic [23:0] backup_color;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        eth_adapter_present;
		logic        eth_link_ready;
		logic        cell_link_ready;
		logic        cloud_connected;
		logic        cloud_disconnected;
	} poll_t;

	typedef struct packed {
		logic [3:0]  fsm_state;
		logic [1:0]  active_link;
		logic        link_changed;
		logic        eth_connect_cmd;
		logic        eth_disconnect_cmd;
		logic        cell_connect_cmd;
		logic        cell_disconnect_cmd;
		logic        cloud_connect_cmd;
		logic        cloud_disconnect_cmd;
		logic [31:0] keepalive_set_ms;
		logic [1:0]  led_theme;
	} result_t;

endpackage

@@ rtl/core/lfc_cfg_regs.sv @@
// Configuration register file for the link failover controller.
// Depends on lfc_pkg for register indexes, reset values and cfg_t.

module lfc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lfc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [lfc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output lfc_pkg::cfg_t                    cfg
);

	lfc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eth_link_timeout_ms   <= lfc_pkg::RST_ETH_LINK_TO;
			cfg_q.eth_cloud_timeout_ms  <= lfc_pkg::RST_ETH_CLOUD_TO;
			cfg_q.cell_link_timeout_ms  <= lfc_pkg::RST_CELL_LINK_TO;
			cfg_q.cell_cloud_timeout_ms <= lfc_pkg::RST_CELL_CLOUD_TO;
			cfg_q.eth_retry_period_ms   <= lfc_pkg::RST_ETH_RETRY;
			cfg_q.eth_keepalive_ms      <= lfc_pkg::RST_ETH_KEEPALIVE;
			cfg_q.cell_keepalive_ms     <= lfc_pkg::RST_CELL_KEEPALIVE;
			cfg_q.backup_color          <= lfc_pkg::RST_BACKUP_COLOR;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lfc_pkg::REG_ETH_LINK_TO:    cfg_q.eth_link_timeout_ms   <= cfg_wdata;
				lfc_pkg::REG_ETH_CLOUD_TO:   cfg_q.eth_cloud_timeout_ms  <= cfg_wdata;
				lfc_pkg::REG_CELL_LINK_TO:   cfg_q.cell_link_timeout_ms  <= cfg_wdata;
				lfc_pkg::REG_CELL_CLOUD_TO:  cfg_q.cell_cloud_timeout_ms <= cfg_wdata;
				lfc_pkg::REG_ETH_RETRY:      cfg_q.eth_retry_period_ms   <= cfg_wdata;
				lfc_pkg::REG_ETH_KEEPALIVE:  cfg_q.eth_keepalive_ms      <= cfg_wdata;
				lfc_pkg::REG_CELL_KEEPALIVE: cfg_q.cell_keepalive_ms     <= cfg_wdata;
				lfc_pkg::REG_BACKUP_COLOR:   cfg_q.backup_color          <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/lfc_core.sv @@
// Failover state machine: state, entry time, adapter flag and active link,
// plus the per-poll step logic. Depends on lfc_pkg.

module lfc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  lfc_pkg::poll_t    poll,
	input  lfc_pkg::cfg_t     cfg,
	output lfc_pkg::result_t  res
);

	typedef enum logic [3:0] {
		ST_START          = 4'd0,
		ST_TRY_ETH        = 4'd1,
		ST_WAIT_ETH_LINK  = 4'd2,
		ST_WAIT_ETH_CLOUD = 4'd3,
		ST_ETH_CLOUD      = 4'd4,
		ST_TRY_CELL       = 4'd5,
		ST_WAIT_CELL_LINK = 4'd6,
		ST_WAIT_CELL_CLOUD = 4'd7,
		ST_CELL_CLOUD     = 4'd8,
		ST_WAIT_TEARDOWN  = 4'd10
	} state_t;

	state_t      state_q, state_d;
	logic [31:0] entered_q, entered_d;
	logic        adapter_q, adapter_d;
	logic [1:0]  link_q, link_d;
	logic [31:0] elapsed;

	assign elapsed = poll.now_ms - entered_q;

	always_comb begin
		state_d   = state_q;
		entered_d = entered_q;
		adapter_d = adapter_q;
		link_d    = link_q;
		res       = '0;
		res.led_theme = lfc_pkg::LED_KEEP;
		unique case (state_q)
			ST_TRY_ETH: begin
				res.led_theme           = lfc_pkg::LED_DEFAULT;
				link_d                  = lfc_pkg::LINK_NONE;
				entered_d               = poll.now_ms;
				res.cell_disconnect_cmd = 1'b1;
				res.eth_connect_cmd     = 1'b1;
				state_d                 = ST_WAIT_ETH_LINK;
			end
			ST_WAIT_ETH_LINK: begin
				if (poll.eth_link_ready) begin
					res.cloud_connect_cmd = 1'b1;
					state_d               = ST_WAIT_ETH_CLOUD;
				end else if (elapsed >= cfg.eth_link_timeout_ms) begin
					state_d = ST_TRY_CELL;
				end
			end
			ST_WAIT_ETH_CLOUD: begin
				if (poll.cloud_connected) begin
					link_d               = lfc_pkg::LINK_ETH;
					res.keepalive_set_ms = cfg.eth_keepalive_ms;
					entered_d            = poll.now_ms;
					state_d              = ST_ETH_CLOUD;
				end else if (elapsed >= cfg.eth_cloud_timeout_ms) begin
					res.cloud_disconnect_cmd = 1'b1;
					res.eth_disconnect_cmd   = 1'b1;
					state_d                  = ST_TRY_CELL;
				end
			end
			ST_ETH_CLOUD: begin
				if (!poll.cloud_connected) begin
					entered_d = poll.now_ms;
					state_d   = ST_WAIT_ETH_CLOUD;
				end
			end
			ST_TRY_CELL: begin
				link_d = lfc_pkg::LINK_NONE;
				res.led_theme = (cfg.backup_color != lfc_pkg::DEFAULT_THEME_COLOR) ?
					lfc_pkg::LED_BACKUP : lfc_pkg::LED_DEFAULT;
				entered_d              = poll.now_ms;
				res.eth_disconnect_cmd = 1'b1;
				res.cell_connect_cmd   = 1'b1;
				state_d                = ST_WAIT_CELL_LINK;
			end
			ST_WAIT_CELL_LINK: begin
				if (poll.cell_link_ready) begin
					res.cloud_connect_cmd = 1'b1;
					state_d               = ST_WAIT_CELL_CLOUD;
				end else if (elapsed >= cfg.cell_link_timeout_ms && adapter_q) begin
					state_d = ST_TRY_ETH;
				end
			end
			ST_WAIT_CELL_CLOUD: begin
				if (poll.cloud_connected) begin
					res.keepalive_set_ms = cfg.cell_keepalive_ms;
					link_d               = lfc_pkg::LINK_CELL;
					entered_d            = poll.now_ms;
					state_d              = ST_CELL_CLOUD;
				end else if (elapsed >= cfg.cell_cloud_timeout_ms && adapter_q) begin
					res.cloud_disconnect_cmd = 1'b1;
					state_d                  = ST_TRY_ETH;
				end
			end
			ST_CELL_CLOUD: begin
				if (!poll.cloud_connected) begin
					entered_d = poll.now_ms;
					state_d   = ST_WAIT_CELL_CLOUD;
				end else if (elapsed >= cfg.eth_retry_period_ms && adapter_q) begin
					// close the cloud session and wait for it to end before trying Ethernet
					res.cloud_disconnect_cmd = 1'b1;
					link_d                   = lfc_pkg::LINK_NONE;
					state_d                  = ST_WAIT_TEARDOWN;
				end
			end
			ST_WAIT_TEARDOWN: begin
				if (poll.cloud_disconnected) begin
					state_d = ST_TRY_ETH;
				end
			end
			default: begin
				// start state; unused codes behave the same
				adapter_d = adapter_q | poll.eth_adapter_present;
				state_d   = adapter_d ? ST_TRY_ETH : ST_TRY_CELL;
			end
		endcase
		res.fsm_state    = state_d;
		res.active_link  = link_d;
		res.link_changed = (link_d != link_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_START;
			entered_q <= '0;
			adapter_q <= 1'b0;
			link_q    <= lfc_pkg::LINK_NONE;
		end else if (step_en) begin
			state_q   <= state_d;
			entered_q <= entered_d;
			adapter_q <= adapter_d;
			link_q    <= link_d;
		end
	end

endmodule

@@ rtl/core/link_failover_controller.sv @@
// Top level of the link failover controller: stream ports, input register,
// result register. Depends on lfc_pkg, lfc_cfg_regs and lfc_core.

// One poll request is taken per clock cycle while the input register is empty or
// advancing. A request is captured in an input register, the failover step runs
// combinationally on it and its result is loaded into the output register when
// the result slot is free or being emptied; the block sustains one poll per
// cycle as long as results are taken. The state machine registers update in the
// same cycle as the result register, which keeps back-to-back polls exact.
// Configuration registers take effect from the next poll processed after the
// write.

module link_failover_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write port
	input  logic                           cfg_we,
	input  logic [lfc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// poll requests
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] now_ms, [32] eth_adapter_present, [33] eth_link_ready,
	// [34] cell_link_ready, [35] cloud_connected, [36] cloud_disconnected, [39:37] zero
	input  logic [lfc_pkg::S_TDATA_W-1:0]  s_tdata,
	// results
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [3:0] fsm_state, [5:4] active_link, [6] link_changed, [7] eth_connect_cmd,
	// [8] eth_disconnect_cmd, [9] cell_connect_cmd, [10] cell_disconnect_cmd,
	// [11] cloud_connect_cmd, [12] cloud_disconnect_cmd, [44:13] keepalive_set_ms,
	// [46:45] led_theme, [47] zero
	output logic [lfc_pkg::M_TDATA_W-1:0]  m_tdata
);

	lfc_pkg::cfg_t    cfg;
	lfc_pkg::poll_t   poll_s1;
	lfc_pkg::result_t res;
	lfc_pkg::result_t res_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;
	logic             step_en;

	lfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// advance when the result slot is free or being emptied
	assign advance  = !out_valid_q || m_tready;
	assign step_en  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			poll_s1.now_ms              <= s_tdata[31:0];
			poll_s1.eth_adapter_present <= s_tdata[32];
			poll_s1.eth_link_ready      <= s_tdata[33];
			poll_s1.cell_link_ready     <= s_tdata[34];
			poll_s1.cloud_connected     <= s_tdata[35];
			poll_s1.cloud_disconnected  <= s_tdata[36];
		end
		if (step_en) begin
			res_q <= res;
		end
	end

	lfc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.poll    (poll_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign m_tvalid = out_valid_q;

	always_comb begin
		m_tdata        = '0;
		m_tdata[3:0]   = res_q.fsm_state;
		m_tdata[5:4]   = res_q.active_link;
		m_tdata[6]     = res_q.link_changed;
		m_tdata[7]     = res_q.eth_connect_cmd;
		m_tdata[8]     = res_q.eth_disconnect_cmd;
		m_tdata[9]     = res_q.cell_connect_cmd;
		m_tdata[10]    = res_q.cell_disconnect_cmd;
		m_tdata[11]    = res_q.cloud_connect_cmd;
		m_tdata[12]    = res_q.cloud_disconnect_cmd;
		m_tdata[44:13] = res_q.keepalive_set_ms;
		m_tdata[46:45] = res_q.led_theme;
	end

endmodule
